[src/mwoa_pkg.sv]
// mwoa_pkg: sizes, register indexes and sequencer codes for the
// mode weighted outlier average core. depends on nothing else.
package mwoa_pkg;

   localparam int MAX_SAMPLES = 128;
   localparam int SAMPLE_BITS = 12;

   // configuration register widths
   localparam int CFG_DATA_BITS  = 8;
   localparam int CFG_INDEX_BITS = 2;
   localparam int MARGIN_BITS    = 7;
   localparam int LEVEL_BITS     = 8;

   // store addressing and match count range (0..MAX_SAMPLES)
   localparam int ADDR_BITS = $clog2(MAX_SAMPLES);
   localparam int CNT_BITS  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
   localparam int STEP_BITS = $clog2(SUM_BITS);

   // level test: count + max_level against peak, no sign needed
   localparam int LVL_BITS = ((CNT_BITS > LEVEL_BITS) ? CNT_BITS : LEVEL_BITS) + 1;

   // margin limit: floor(margin * n / 100) through a reciprocal
   localparam int PROD_BITS    = MARGIN_BITS + CNT_BITS;
   localparam int DIV100_SHIFT = 24;
   localparam int DIV100_RECIP = ((2 ** DIV100_SHIFT) + 99) / 100;
   localparam int RECIP_BITS   = $clog2(DIV100_RECIP + 1);
   localparam int SCALED_BITS  = PROD_BITS + RECIP_BITS;
   localparam int LIMIT_BITS   = CNT_BITS + 1;

   // reset values of the registers
   localparam int SAMPLE_COUNT_RESET   = 100;
   localparam int MAX_LEVEL_RESET      = 0;
   localparam int MARGIN_PERCENT_RESET = 10;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      REG_SAMPLE_COUNT   = 2'd0,
      REG_MAX_LEVEL      = 2'd1,
      REG_MARGIN_PERCENT = 2'd2
   } reg_index_type;

   typedef enum logic [4:0] {
      ST_FILL  = 5'b00001,
      ST_COUNT = 5'b00010,
      ST_KEEP  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

endpackage

[src/mode_weighted_outlier_average_core.sv]
// mode_weighted_outlier_average_core: batch store, pairwise match counting,
// outlier rejection and floor mean. depends on mwoa_pkg.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_sample
//   rsp      out        rsp_valid/rsp_stall   rsp_average, rsp_no_valid
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// a batch of n samples is taken one per cycle, then the match counting pass
// compares every pair (one compare a cycle through the two read ports of the
// sample store), the keep pass tests each entry, the divider forms the floor
// mean and the result register is loaded; the compare loop dominates the time.
// reset is synchronous; the stores have no clearing pass, a batch only reads
// entries it wrote. req_stall is high outside the fill phase; a result waiting
// on rsp_stall does not block the next batch until that batch is done.
module mode_weighted_outlier_average_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [mwoa_pkg::SAMPLE_BITS-1:0]       req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [mwoa_pkg::SAMPLE_BITS-1:0]       rsp_average,
   output logic                                   rsp_no_valid,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mwoa_pkg::CFG_INDEX_BITS-1:0]    csr_index,
   input  logic [mwoa_pkg::CFG_DATA_BITS-1:0]     csr_data
);

   localparam int AW  = mwoa_pkg::ADDR_BITS;
   localparam int CW  = mwoa_pkg::CNT_BITS;
   localparam int SB  = mwoa_pkg::SAMPLE_BITS;
   localparam int SMB = mwoa_pkg::SUM_BITS;
   localparam int LB  = mwoa_pkg::LVL_BITS;

   // configuration registers
   logic [mwoa_pkg::CFG_DATA_BITS-1:0] sample_count_ff;
   logic [mwoa_pkg::LEVEL_BITS-1:0]    max_level_ff;
   logic [mwoa_pkg::MARGIN_BITS-1:0]   margin_ff;

   // sequencer
   mwoa_pkg::state_type state_ff, state_in;
   logic [AW-1:0]  fill_ff, fill_in;
   logic [AW-1:0]  idx_i_ff, idx_i_in;
   logic [AW-1:0]  idx_j_ff, idx_j_in;
   logic           issue_ff, issue_in;

   // read pipeline tags
   logic           rd_valid_ff, rd_valid_in;
   logic           rd_first_ff, rd_first_in;
   logic           rd_last_ff, rd_last_in;
   logic           rd_end_ff, rd_end_in;
   logic [AW-1:0]  rd_i_ff, rd_i_in;

   // batch state
   logic [CW-1:0]  acc_ff, acc_in;
   logic [CW-1:0]  peak_ff, peak_in;
   logic [SMB-1:0] sum_ff, sum_in;
   logic [CW-1:0]  num_ff, num_in;
   logic [CW-1:0]  rem_ff, rem_in;
   logic [mwoa_pkg::STEP_BITS-1:0] step_ff, step_in;

   // margin limit pipeline, runs freely off the registers
   logic [mwoa_pkg::PROD_BITS-1:0]  prod_ff;
   logic [mwoa_pkg::LIMIT_BITS-1:0] limit_ff;
   logic [mwoa_pkg::SCALED_BITS-1:0] scaled;

   // result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]  average_ff;
   logic           no_valid_ff;
   logic           load_rsp;

   // memories
   logic [SB-1:0]  store_mem [mwoa_pkg::MAX_SAMPLES];
   logic [CW-1:0]  counts_mem [mwoa_pkg::MAX_SAMPLES];
   logic [SB-1:0]  rd_a_ff, rd_b_ff;
   logic [CW-1:0]  rd_cnt_ff;
   logic           store_we;
   logic           counts_we;
   logic [CW-1:0]  counts_wdata;

   // batch size: zero reads as one, saturated to the store depth
   logic [CW-1:0]  batch_n;
   logic [CW-1:0]  batch_last;
   logic           last_i, last_j;

   // compare and keep logic
   logic           pair_eq;
   logic [CW-1:0]  cnt_new;
   logic           level_ok, margin_ok, keep;
   logic [SMB-1:0] kept_sum_next;
   logic [CW-1:0]  kept_num_next;
   logic [CW:0]    trial;
   logic           trial_ge;
   logic           req_xfer;

   always_comb begin
      if (sample_count_ff == '0) begin
         batch_n = CW'(1);
      end else if (32'(sample_count_ff) > 32'(mwoa_pkg::MAX_SAMPLES)) begin
         batch_n = CW'(mwoa_pkg::MAX_SAMPLES);
      end else begin
         batch_n = CW'(sample_count_ff);
      end
   end

   assign batch_last = batch_n - CW'(1);
   assign last_i     = (CW'(idx_i_ff) == batch_last);
   assign last_j     = (CW'(idx_j_ff) == batch_last);

   assign req_stall = (state_ff != mwoa_pkg::ST_FILL);
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // configuration writes, a new batch size drops the partial batch
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= mwoa_pkg::CFG_DATA_BITS'(mwoa_pkg::SAMPLE_COUNT_RESET);
         max_level_ff    <= mwoa_pkg::LEVEL_BITS'(mwoa_pkg::MAX_LEVEL_RESET);
         margin_ff       <= mwoa_pkg::MARGIN_BITS'(mwoa_pkg::MARGIN_PERCENT_RESET);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mwoa_pkg::REG_SAMPLE_COUNT:   sample_count_ff <= csr_data;
            mwoa_pkg::REG_MAX_LEVEL:      max_level_ff    <= csr_data;
            mwoa_pkg::REG_MARGIN_PERCENT: margin_ff       <= csr_data[mwoa_pkg::MARGIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // margin limit = floor(margin * n / 100), two registered multiplies
   assign scaled = mwoa_pkg::SCALED_BITS'(prod_ff) *
                   mwoa_pkg::SCALED_BITS'(mwoa_pkg::DIV100_RECIP);

   always_ff @(posedge clock) begin
      prod_ff  <= mwoa_pkg::PROD_BITS'(margin_ff) * mwoa_pkg::PROD_BITS'(batch_n);
      limit_ff <= mwoa_pkg::LIMIT_BITS'(scaled >> mwoa_pkg::DIV100_SHIFT);
   end

   // compare of the pair read last cycle, count restarts on the first column
   assign pair_eq = (rd_a_ff == rd_b_ff);
   assign cnt_new = (rd_first_ff ? '0 : acc_ff) + CW'(pair_eq);

   // keep tests on the entry read last cycle
   assign level_ok  = (max_level_ff == '0) ||
                      ((LB'(rd_cnt_ff) + LB'(max_level_ff)) > LB'(peak_ff));
   assign margin_ok = (mwoa_pkg::LIMIT_BITS'(rd_cnt_ff) > limit_ff);
   assign keep      = rd_valid_ff && level_ok && margin_ok;
   assign kept_sum_next = sum_ff + (keep ? SMB'(rd_a_ff) : '0);
   assign kept_num_next = num_ff + CW'(keep);

   // restoring divide, one quotient bit a cycle shifted into sum_ff
   assign trial    = {rem_ff, sum_ff[SMB-1]};
   assign trial_ge = (trial >= {1'b0, num_ff});

   assign load_rsp = (state_ff == mwoa_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_first_in  = (idx_j_ff == '0);
      rd_last_in   = last_j;
      rd_end_in    = last_i && last_j;
      rd_i_in      = idx_i_ff;
      acc_in       = acc_ff;
      peak_in      = peak_ff;
      sum_in       = sum_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      store_we     = 1'b0;
      counts_we    = 1'b0;
      counts_wdata = cnt_new;

      case (state_ff)
         mwoa_pkg::ST_FILL: begin
            if (req_xfer) begin
               store_we = 1'b1;
               if (CW'(fill_ff) == batch_last) begin
                  fill_in  = '0;
                  idx_i_in = '0;
                  idx_j_in = '0;
                  issue_in = 1'b1;
                  peak_in  = '0;
                  state_in = mwoa_pkg::ST_COUNT;
               end else begin
                  fill_in = fill_ff + AW'(1);
               end
            end
         end
         mwoa_pkg::ST_COUNT: begin
            // issue pair (i, j)
            if (issue_ff) begin
               rd_valid_in = 1'b1;
               if (last_j) begin
                  idx_j_in = '0;
                  if (last_i) begin
                     issue_in = 1'b0;
                  end else begin
                     idx_i_in = idx_i_ff + AW'(1);
                  end
               end else begin
                  idx_j_in = idx_j_ff + AW'(1);
               end
            end
            // compare the pair read last cycle
            if (rd_valid_ff) begin
               acc_in = cnt_new;
               if (rd_last_ff) begin
                  counts_we = 1'b1;
                  if (cnt_new > peak_ff) begin
                     peak_in = cnt_new;
                  end
               end
               if (rd_end_ff) begin
                  idx_i_in = '0;
                  issue_in = 1'b1;
                  sum_in   = '0;
                  num_in   = '0;
                  state_in = mwoa_pkg::ST_KEEP;
               end
            end
         end
         mwoa_pkg::ST_KEEP: begin
            rd_last_in = last_i;
            if (issue_ff) begin
               rd_valid_in = 1'b1;
               if (last_i) begin
                  issue_in = 1'b0;
               end else begin
                  idx_i_in = idx_i_ff + AW'(1);
               end
            end
            if (rd_valid_ff) begin
               sum_in = kept_sum_next;
               num_in = kept_num_next;
               if (rd_last_ff) begin
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = mwoa_pkg::ST_DIV;
               end
            end
         end
         mwoa_pkg::ST_DIV: begin
            rem_in = trial_ge ? CW'(trial - {1'b0, num_ff}) : trial[CW-1:0];
            sum_in = {sum_ff[SMB-2:0], trial_ge};
            step_in = step_ff + mwoa_pkg::STEP_BITS'(1);
            if (32'(step_ff) == SMB - 1) begin
               state_in = mwoa_pkg::ST_OUT;
            end
         end
         mwoa_pkg::ST_OUT: begin
            if (load_rsp) begin
               rsp_valid_in = 1'b1;
               state_in     = mwoa_pkg::ST_FILL;
            end
         end
         default: begin
            state_in = mwoa_pkg::ST_FILL;
         end
      endcase

      // a rewritten batch size restarts the fill
      if (csr_valid && csr_ready && (csr_index == mwoa_pkg::REG_SAMPLE_COUNT)) begin
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwoa_pkg::ST_FILL;
         fill_ff      <= '0;
         issue_ff     <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      idx_i_ff    <= idx_i_in;
      idx_j_ff    <= idx_j_in;
      rd_first_ff <= rd_first_in;
      rd_last_ff  <= rd_last_in;
      rd_end_ff   <= rd_end_in;
      rd_i_ff     <= rd_i_in;
      acc_ff      <= acc_in;
      peak_ff     <= peak_in;
      sum_ff      <= sum_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      if (load_rsp) begin
         no_valid_ff <= (num_ff == '0);
         average_ff  <= (num_ff == '0) ? '0 : sum_ff[SB-1:0];
      end
   end

   // sample store: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[fill_ff] <= req_sample;
      end
      rd_a_ff <= store_mem[idx_i_ff];
      rd_b_ff <= store_mem[idx_j_ff];
   end

   // match count store
   always_ff @(posedge clock) begin
      if (counts_we) begin
         counts_mem[rd_i_ff] <= counts_wdata;
      end
      rd_cnt_ff <= counts_mem[idx_i_ff];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_average  = average_ff;
   assign rsp_no_valid = no_valid_ff;

endmodule
